// File: sv/b64d_pkg.sv
package b64d_pkg;

    typedef enum logic [1:0] {
        ACT_CHAR  = 2'd0,
        ACT_CLOSE = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_BYTE  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_SKIP_LINE_ENDS   = 3'd0,
        CFG_SKIP_INVALID     = 3'd1,
        CFG_PADDING_OPTIONAL = 3'd2,
        CFG_SKIP_BIT_CHECK   = 3'd3,
        CFG_CODE62_CHAR      = 3'd4,
        CFG_CODE63_CHAR      = 3'd5,
        CFG_PAD_CHAR         = 3'd6
    } t_cfg_index;

    localparam logic [3:0] PH_DATA0   = 4'd0;
    localparam logic [3:0] PH_DATA1   = 4'd1;
    localparam logic [3:0] PH_DATA2   = 4'd2;
    localparam logic [3:0] PH_DATA3   = 4'd3;
    localparam logic [3:0] PH_PAD0    = 4'd4;
    localparam logic [3:0] PH_PAD1    = 4'd5;
    localparam logic [3:0] PH_PAD2    = 4'd6;
    localparam logic [3:0] PH_PAD3    = 4'd7;
    localparam logic [3:0] PH_STOPPED = 4'd15;

    localparam logic [7:0] NO_BYTE   = 8'hFF;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;

    localparam logic       RST_SKIP_LINE_ENDS   = 1'b1;
    localparam logic       RST_SKIP_INVALID     = 1'b0;
    localparam logic       RST_PADDING_OPTIONAL = 1'b0;
    localparam logic       RST_SKIP_BIT_CHECK   = 1'b1;
    localparam logic [7:0] RST_CODE62_CHAR      = 8'd43;
    localparam logic [7:0] RST_CODE63_CHAR      = 8'd47;
    localparam logic [7:0] RST_PAD_CHAR         = 8'd61;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] byte_out;
        logic       stopped;
    } t_out_item;

    typedef struct packed {
        logic       skip_line_ends;
        logic       skip_invalid;
        logic       padding_optional;
        logic       skip_bit_check;
        logic [7:0] code62_char;
        logic [7:0] code63_char;
        logic [7:0] pad_char;
    } t_cfg;

    typedef struct packed {
        logic [3:0] phase;
        logic [5:0] leftover;
    } t_state;

endpackage

// File: sv/base64_stream_decoder_core.sv
// Base64 stream decoder: one character (or a close or clear command) per input beat,
// exactly one result beat per input beat, carrying status, the decoded byte and a
// stopped flag. Sustained rate is one beat per cycle while the output is not stalled;
// a beat passes the input register, then the phase/leftover update and the result
// register together; the phase/leftover state loop closes within that update, which
// sets the rate. Configuration writes take effect on the next beat and are always
// ready; indexes beyond the register list are dropped.
module base64_stream_decoder_core
    import b64d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      advance;

    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    b64d_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.skip_line_ends   <= RST_SKIP_LINE_ENDS;
            r_cfg.skip_invalid     <= RST_SKIP_INVALID;
            r_cfg.padding_optional <= RST_PADDING_OPTIONAL;
            r_cfg.skip_bit_check   <= RST_SKIP_BIT_CHECK;
            r_cfg.code62_char      <= RST_CODE62_CHAR;
            r_cfg.code63_char      <= RST_CODE63_CHAR;
            r_cfg.pad_char         <= RST_PAD_CHAR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SKIP_LINE_ENDS:   r_cfg.skip_line_ends   <= i_cfg_data[0];
                CFG_SKIP_INVALID:     r_cfg.skip_invalid     <= i_cfg_data[0];
                CFG_PADDING_OPTIONAL: r_cfg.padding_optional <= i_cfg_data[0];
                CFG_SKIP_BIT_CHECK:   r_cfg.skip_bit_check   <= i_cfg_data[0];
                CFG_CODE62_CHAR:      r_cfg.code62_char      <= i_cfg_data;
                CFG_CODE63_CHAR:      r_cfg.code63_char      <= i_cfg_data;
                CFG_PAD_CHAR:         r_cfg.pad_char         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_DATA0, leftover: 6'd0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            // state moves only when the held beat is handed to the result register
            if (advance && r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance && r_in_valid) begin
            r_out_item <= n_out_item;
        end
    end

    a_no_byte_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_item.status != ST_BYTE) |-> r_out_item.byte_out == NO_BYTE)
        else $error("byte_out not 0xFF on a beat without a byte");

    a_stopped_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_item.stopped == (r_state.phase == PH_STOPPED))
        else $error("stopped flag disagrees with phase");

    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_item.status == ST_ERROR) |-> r_out_item.stopped)
        else $error("error result without stop");

    a_stopped_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_STOPPED |-> r_state.leftover == 6'd0)
        else $error("leftover bits kept while stopped");

endmodule

// File: sv/b64d_step.sv
module b64d_step
    import b64d_pkg::*;
(
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    logic       is_value;
    logic       is_pad;
    logic       is_line_end;
    logic [5:0] value;
    logic       err;
    logic       bit_err;
    t_state     nxt;
    logic [1:0] status;
    logic [7:0] byte_val;
    logic [7:0] c;

    assign c       = i_item.char_in;
    assign bit_err = !i_cfg.skip_bit_check && (i_state.leftover != 6'd0);

    // classification order: 62, 63, padding, line end, alphabet
    always_comb begin
        is_value    = 1'b0;
        is_pad      = 1'b0;
        is_line_end = 1'b0;
        value       = 6'd0;
        priority if (c == i_cfg.code62_char) begin
            is_value = 1'b1;
            value    = 6'd62;
        end else if (c == i_cfg.code63_char) begin
            is_value = 1'b1;
            value    = 6'd63;
        end else if (c == i_cfg.pad_char) begin
            is_pad = 1'b1;
        end else if (c == CHAR_LF || c == CHAR_CR) begin
            is_line_end = 1'b1;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            is_value = 1'b1;
            value    = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            is_value = 1'b1;
            value    = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            is_value = 1'b1;
            value    = 6'(c - 8'h30 + 8'd52);
        end else begin
            // not in the alphabet
            is_value = 1'b0;
        end
    end

    always_comb begin
        nxt      = i_state;
        status   = ST_NONE;
        byte_val = NO_BYTE;
        err      = 1'b0;
        unique case (i_item.action)
            ACT_CHAR: begin
                if (is_value) begin
                    unique case (i_state.phase)
                        PH_DATA0: begin
                            nxt.leftover = value;
                            nxt.phase    = PH_DATA1;
                        end
                        PH_DATA1: begin
                            byte_val     = {i_state.leftover, value[5:4]};
                            nxt.leftover = {2'b00, value[3:0]};
                            nxt.phase    = PH_DATA2;
                            status       = ST_BYTE;
                        end
                        PH_DATA2: begin
                            byte_val     = {i_state.leftover[3:0], value[5:2]};
                            nxt.leftover = {4'b0000, value[1:0]};
                            nxt.phase    = PH_DATA3;
                            status       = ST_BYTE;
                        end
                        PH_DATA3: begin
                            byte_val     = {i_state.leftover[1:0], value};
                            nxt.leftover = 6'd0;
                            nxt.phase    = PH_DATA0;
                            status       = ST_BYTE;
                        end
                        default: err = 1'b1;
                    endcase
                end else if (is_pad) begin
                    nxt.leftover = 6'd0;
                    if (bit_err) begin
                        err = 1'b1;
                    end else begin
                        unique case (i_state.phase)
                            PH_DATA0, PH_PAD3: nxt.phase = PH_PAD0;
                            PH_DATA1, PH_PAD0: nxt.phase = PH_PAD1;
                            PH_DATA2, PH_PAD1: nxt.phase = PH_PAD2;
                            PH_DATA3, PH_PAD2: nxt.phase = PH_PAD3;
                            default:           err = 1'b1;
                        endcase
                    end
                end else if (is_line_end) begin
                    err = !i_cfg.skip_line_ends;
                end else begin
                    err = !i_cfg.skip_invalid;
                end
            end
            ACT_CLOSE: begin
                nxt.leftover = 6'd0;
                if (bit_err) begin
                    err = 1'b1;
                end else if (i_cfg.padding_optional) begin
                    unique case (i_state.phase)
                        PH_DATA1: nxt.phase = PH_PAD1;
                        PH_DATA2: nxt.phase = PH_PAD2;
                        PH_DATA3: nxt.phase = PH_PAD3;
                        PH_DATA0, PH_PAD0, PH_PAD1, PH_PAD2, PH_PAD3:
                            nxt.phase = PH_STOPPED;
                        default: err = 1'b1;
                    endcase
                end else if (i_state.phase == PH_DATA0 || i_state.phase == PH_PAD3) begin
                    nxt.phase = PH_STOPPED;
                end else begin
                    err = 1'b1;
                end
            end
            ACT_CLEAR: begin
                nxt.phase    = PH_DATA0;
                nxt.leftover = 6'd0;
            end
            default: ;
        endcase
        if (err) begin
            nxt.phase    = PH_STOPPED;
            nxt.leftover = 6'd0;
            status       = ST_ERROR;
            byte_val     = NO_BYTE;
        end
    end

    assign o_state           = nxt;
    assign o_result.status   = status;
    assign o_result.byte_out = byte_val;
    assign o_result.stopped  = (nxt.phase == PH_STOPPED);

endmodule
